// ----- rtl/core/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: shared package
// Field widths, configuration register indexes and default sizes used by the
// Sobel edge detector core and its submodules.
// ----------------------------------------------------------------------------
package sgm_pkg;

  // Pixel and result field widths.
  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 11;
  localparam int MAG_W     = 11;
  localparam int SQ_W      = 2 * MAG_W;   // radicand of the square root unit
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;

  // Configuration port.
  localparam int IW_W      = 11;          // image_width register width
  localparam int CFG_W     = 16;          // widest register
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [IW_W-1:0]  IMAGE_WIDTH_RST  = IW_W'(1024);
  localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RST = ROW_W'(1024);

  // Default line buffer depth.
  localparam int MAX_WIDTH_DEF = 1024;

endpackage

// ----- rtl/core/sobel_gradient_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: top level
// 3x3 Sobel edge detector on a raster stream of 8-bit grayscale pixels, with
// per-pixel horizontal and vertical gradients and their integer magnitude.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Moves
//   -------   ---------------------------------------   ------------------------
//   config    cfg_we, cfg_index, cfg_data               register write, no wait
//   input     in_valid, in_ready, pixel                 one pixel per transaction
//   output    out_valid, out_ready, grad_x, grad_y,     one result per transaction
//             magnitude, out_row, out_col, run_last,
//             frame_last
//
// A pixel that produces no result (row 0) passes the idle and read states
// only; one whose only result is itself as a bottom border pixel (column 0
// of the last row) goes on from the read state to the emit state; one that
// produces a lagged result (1 to 3 results in all) passes the square, sum
// and root states first. The root state waits for the iterative square
// root unit, which retires one magnitude bit per cycle.
// Reset is synchronous and active high; it clears the counters, the window
// registers and the configuration registers (width and height 1024). The line
// buffer memory is not cleared: only entries written earlier in the same frame
// ever reach a result.
// A new pixel is taken once the previous pixel's results are all loaded into
// the output register, so the final result may still be waiting there while
// the next pixel transaction completes. A stalled output holds the sequencer in
// its emit state and nothing else.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_top
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIX_W-1:0]         pixel,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic [MAG_W-1:0]         magnitude,
  output logic [ROW_W-1:0]         out_row,
  output logic [OUT_COL_W-1:0]     out_col,
  output logic                     run_last,
  output logic                     frame_last
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * PIX_W;
  localparam int SUM_W  = PIX_W + 2;
  localparam int PSQ_W  = 2 * GRAD_W;
  localparam int SQH_W  = SQ_W - 2;     // one square fits in this width

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_EMIT
  } state_t;

  // Pending results of the current pixel, in reverse of emission order.
  typedef struct packed {
    logic last_row;    // bottom border pixel in the same column
    logic right_edge;  // right border pixel of the row above
    logic lagged;      // pixel one row up and one column left
  } pend_t;

  state_t state;
  pend_t  pend;
  pend_t  pend_next;
  pend_t  pend_left;

  // Configuration and derived frame limits.
  logic [IW_W-1:0]   image_width;
  logic [ROW_W-1:0]  image_height;
  logic [ADDR_W-1:0] col_last;
  logic [ROW_W-1:0]  row_last;

  // Raster position of the next pixel, and of the pixel being worked on.
  logic [ROW_W-1:0]  row_cnt;
  logic [ADDR_W-1:0] col_cnt;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] cur_col;

  logic [PIX_W-1:0]  pixel_r;
  logic [PIX_W-1:0]  win [6];
  logic [LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;

  logic [SUM_W-1:0]         sum_left;
  logic [SUM_W-1:0]         sum_right;
  logic [SUM_W-1:0]         sum_top;
  logic [SUM_W-1:0]         sum_bot;
  logic signed [GRAD_W-1:0] gx_calc;
  logic signed [GRAD_W-1:0] gy_calc;
  logic                     interior;
  logic signed [GRAD_W-1:0] gx_r;
  logic signed [GRAD_W-1:0] gy_r;
  logic signed [PSQ_W-1:0]  prod_x;
  logic signed [PSQ_W-1:0]  prod_y;
  logic [SQH_W-1:0]         sq_x;
  logic [SQH_W-1:0]         sq_y;
  logic [SQ_W-1:0]          radicand;
  logic [MAG_W-1:0]         root;
  logic                     root_done;

  logic                     in_accept;
  logic                     emit_go;
  logic [ADDR_W-1:0]        col_dec;
  logic [ROW_W-1:0]         row_dec;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Clamp the programmed size to the legal frame: width in [3, MAX_WIDTH],
  // height at least 3.
  always_comb begin
    if (image_width < IW_W'(3)) begin
      col_last = ADDR_W'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      col_last = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      col_last = ADDR_W'(image_width - IW_W'(1));
    end
    if (image_height < ROW_W'(3)) begin
      row_last = ROW_W'(2);
    end else begin
      row_last = image_height - ROW_W'(1);
    end
  end

  // Line buffer: the upper byte is the row two up, the lower byte the row one
  // up. Each pixel reads its column in the accept cycle and writes it back in
  // the read state; the next pixel cannot be read before that write lands.
  assign top = line_rd[LINE_W-1 -: PIX_W];
  assign mid = line_rd[PIX_W-1:0];

  sgm_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W),
    .DATA_W (LINE_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_cnt),
    .rd_data (line_rd),
    .wr_en   (state == S_READ),
    .wr_addr (col_cnt),
    .wr_data ({mid, pixel_r})
  );

  // Window columns: win[0], win[2], win[4] are the left column (two pixels
  // back), win[1], win[3], win[5] the center column; the right column comes
  // straight from the line buffer and the new pixel.
  always_comb begin
    sum_left  = SUM_W'(win[0]) + {1'b0, win[2], 1'b0} + SUM_W'(win[4]);
    sum_right = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(pixel_r);
    sum_top   = SUM_W'(win[0]) + {1'b0, win[1], 1'b0} + SUM_W'(top);
    sum_bot   = SUM_W'(win[4]) + {1'b0, win[5], 1'b0} + SUM_W'(pixel_r);
    gx_calc   = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
    gy_calc   = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
    interior  = (row_cnt >= ROW_W'(2)) && (col_cnt >= ADDR_W'(2));
  end

  // Results this pixel causes.
  always_comb begin
    pend_next.lagged     = (row_cnt != '0) && (col_cnt != '0);
    pend_next.right_edge = (row_cnt != '0) && (col_cnt == col_last);
    pend_next.last_row   = (row_cnt == row_last);
  end

  assign prod_x   = PSQ_W'(gx_r) * PSQ_W'(gx_r);
  assign prod_y   = PSQ_W'(gy_r) * PSQ_W'(gy_r);
  assign radicand = SQ_W'(sq_x) + SQ_W'(sq_y);

  sgm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SUM),
    .radicand (radicand),
    .root     (root),
    .done     (root_done)
  );

  // Datapath registers, counters and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      row_cnt      <= '0;
      col_cnt      <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        pixel_r <= pixel;
      end
      if (state == S_READ) begin
        cur_row <= row_cnt;
        cur_col <= col_cnt;
        gx_r    <= interior ? gx_calc : '0;
        gy_r    <= interior ? gy_calc : '0;
        win[0]  <= win[1];
        win[1]  <= top;
        win[2]  <= win[3];
        win[3]  <= mid;
        win[4]  <= win[5];
        win[5]  <= pixel_r;
      end
      if (state == S_SQUARE) begin
        sq_x <= prod_x[SQH_W-1:0];
        sq_y <= prod_y[SQH_W-1:0];
      end
      // A register write restarts the frame; the line buffer keeps its data.
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
        row_cnt <= '0;
        col_cnt <= '0;
      end else if (state == S_READ) begin
        if (col_cnt == col_last) begin
          col_cnt <= '0;
          row_cnt <= (row_cnt == row_last) ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + ADDR_W'(1);
        end
      end
    end
  end

  assign col_dec = cur_col - ADDR_W'(1);
  assign row_dec = cur_row - ROW_W'(1);
  assign emit_go = (state == S_EMIT) && (!out_valid || out_ready);

  // Results left once the oldest pending one is loaded.
  always_comb begin
    pend_left = pend;
    if (pend.lagged) begin
      pend_left.lagged = 1'b0;
    end else if (pend.right_edge) begin
      pend_left.right_edge = 1'b0;
    end else begin
      pend_left.last_row = 1'b0;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          pend <= pend_next;
          if (pend_next == '0) begin
            state <= S_IDLE;
          end else if (pend_next.lagged) begin
            state <= S_SQUARE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SQUARE: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            pend       <= pend_left;
            run_last   <= (pend_left == '0);
            frame_last <= 1'b0;
            if (pend.lagged) begin
              grad_x    <= gx_r;
              grad_y    <= gy_r;
              magnitude <= root;
              out_row   <= row_dec;
              out_col   <= OUT_COL_W'(col_dec);
            end else if (pend.right_edge) begin
              grad_x    <= '0;
              grad_y    <= '0;
              magnitude <= '0;
              out_row   <= row_dec;
              out_col   <= OUT_COL_W'(col_last);
            end else begin
              grad_x     <= '0;
              grad_y     <= '0;
              magnitude  <= '0;
              out_row    <= cur_row;
              out_col    <= OUT_COL_W'(cur_col);
              frame_last <= (cur_col == col_last);
            end
            if (pend_left == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The end-of-frame result always closes its pixel's run.
  a_frame_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame_last without run_last");

  // The column counter never passes the clamped right edge.
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= col_last)
    else $error("column counter beyond frame width");

  // The row counter never passes the clamped bottom edge.
  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row_cnt <= row_last)
    else $error("row counter beyond frame height");

  // The square root unit finishes only while the sequencer waits for it.
  a_root_done_in_root: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("square root finished outside its wait state");

  // An accepted pixel always goes to the line buffer read stage next.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ)
    else $error("accepted pixel did not enter the read stage");
`endif

endmodule

// ----- rtl/core/sgm_line_ram.sv -----
// ----------------------------------------------------------------------------
// Sobel line buffer memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port; holds the two previous image rows packed side by side.
// ----------------------------------------------------------------------------
module sgm_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sgm_isqrt.sv -----
// ----------------------------------------------------------------------------
// Sobel iterative integer square root
// Restoring digit-by-digit square root: one result bit per cycle, giving the
// floor of the square root of the radicand as a MAG_W-bit root.
// ----------------------------------------------------------------------------
module sgm_isqrt
  import sgm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output logic [MAG_W-1:0] root,
  output logic             done
);

  localparam int STEPS = MAG_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = MAG_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic [SQ_W-1:0]  rad_sh;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [TRY_W-1:0] rem_in;
  logic [TRY_W-1:0] trial;
  logic [TRY_W-1:0] rem_sub;
  logic             fits;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_in  = {rem, rad_sh[SQ_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    fits    = (rem_in >= trial);
    rem_sub = rem_in - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
      cnt    <= CNT_W'(STEPS);
      done   <= 1'b0;
    end else if (cnt != '0) begin
      rad_sh <= rad_sh << 2;
      rem    <= fits ? rem_sub[REM_W-1:0] : rem_in[REM_W-1:0];
      root   <= {root[MAG_W-2:0], fits};
      cnt    <= cnt - CNT_W'(1);
      done   <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient magnitude: self-checking testbench
// Streams raster frames into the Sobel core with random gaps and output
// stalls. An internal predictor follows the pixel stream and queues the
// expected results. Every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
  // Cycles to let a pixel that causes no result finish before a register write.
  localparam int SETTLE_CYCLES = 40;
  // Long receiver hold used to fill the core and stall its input.
  localparam int HOLD_CYCLES   = 400;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 20;

  // One expected result transaction.
  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic [ROW_W-1:0]         row;
    logic [OUT_COL_W-1:0]     col;
    logic                     run_last;
    logic                     frame_last;
  } sobel_result_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index  = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]         cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic [PIX_W-1:0]         pixel      = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic [ROW_W-1:0]         out_row;
  logic [OUT_COL_W-1:0]     out_col;
  logic                     run_last;
  logic                     frame_last;

  sobel_gradient_magnitude_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .magnitude  (magnitude),
    .out_row    (out_row),
    .out_col    (out_col),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the line buffers, the window, the
  // raster position and the two size registers.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  rows_two_back [LINE_DEPTH];
  logic [PIX_W-1:0]  rows_one_back [LINE_DEPTH];
  logic [PIX_W-1:0]  window_pix [6];
  int unsigned       raster_row = 0;
  int unsigned       raster_col = 0;
  logic [IW_W-1:0]   width_reg  = IMAGE_WIDTH_RST;
  logic [ROW_W-1:0]  height_reg = IMAGE_HEIGHT_RST;

  sobel_result_t     pending_results[$];

  // Run bookkeeping.
  int  error_count     = 0;
  int  pixels_sent     = 0;
  int  results_checked = 0;
  int  frames_seen     = 0;
  int  random_items    = 0;
  int  idle_cycles     = 0;

  // Idling controls shared by the test tasks and the result sink.
  bit  source_gaps     = 1'b1;
  bit  sink_stalls     = 1'b1;
  int  hold_requests   = 0;
  int  holds_served    = 0;

  // The frame size actually used by the core after clamping.
  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Floor of the square root, built one bit at a time from the top.
  function automatic int unsigned int_sqrt(input int unsigned value);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root;
  endfunction

  function automatic sobel_result_t make_result(input int gx, input int gy,
                                                input int unsigned row,
                                                input int unsigned col);
    sobel_result_t res;
    res.gx         = gx[GRAD_W-1:0];
    res.gy         = gy[GRAD_W-1:0];
    res.mag        = MAG_W'(int_sqrt(gx * gx + gy * gy));
    res.row        = row[ROW_W-1:0];
    res.col        = col[OUT_COL_W-1:0];
    res.run_last   = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  // Advances the predictor by one accepted pixel and queues what it causes.
  // The new pixel completes the neighborhood of the pixel one row up and
  // one column left; the right column and the last row are border results.
  function automatic void predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   r;
    int unsigned   c;
    int            top;
    int            mid;
    int            bot;
    int            gx;
    int            gy;
    sobel_result_t burst[$];
    w = active_width();
    h = active_height();
    r = (raster_row >= h) ? 0 : raster_row;
    c = (raster_col >= w) ? 0 : raster_col;

    top = rows_two_back[c];
    mid = rows_one_back[c];
    bot = px;
    rows_two_back[c] = mid[PIX_W-1:0];
    rows_one_back[c] = px;

    if (r >= 1 && c >= 1) begin
      gx = 0;
      gy = 0;
      if (r >= 2 && c >= 2) begin
        gx = (window_pix[0] + 2 * window_pix[2] + window_pix[4]) - (top + 2 * mid + bot);
        gy = (window_pix[0] + 2 * window_pix[1] + top) - (window_pix[4] + 2 * window_pix[5] + bot);
      end
      burst.push_back(make_result(gx, gy, r - 1, c - 1));
      if (c == w - 1) burst.push_back(make_result(0, 0, r - 1, w - 1));
    end
    if (r == h - 1) burst.push_back(make_result(0, 0, h - 1, c));

    if (burst.size() > 0) begin
      burst[burst.size() - 1].run_last = 1'b1;
      if (burst[burst.size() - 1].row == h - 1 && c == w - 1)
        burst[burst.size() - 1].frame_last = 1'b1;
    end
    foreach (burst[i]) pending_results.push_back(burst[i]);

    window_pix[0] = window_pix[1];
    window_pix[1] = top[PIX_W-1:0];
    window_pix[2] = window_pix[3];
    window_pix[3] = mid[PIX_W-1:0];
    window_pix[4] = window_pix[5];
    window_pix[5] = px;

    if (c + 1 >= w) begin
      raster_col = 0;
      raster_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      raster_col = c + 1;
      raster_row = r;
    end
  endfunction

  // Any register write restarts the frame; the line buffers keep their data.
  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] value);
    if (idx == REG_IMAGE_WIDTH) width_reg = value[IW_W-1:0];
    else height_reg = value[ROW_W-1:0];
    raster_row = 0;
    raster_col = 0;
  endfunction

  // No gap half the time, a short one most of the rest, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Full range most of the time, hard black and white otherwise so that
  // large gradients of both signs come up often.
  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(0, 2) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. The task is entered right after a rising edge. valid stays
  // high between back-to-back transactions and is dropped only for a gap.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int gap;
    gap = source_gaps ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    do @(posedge clk); while (!in_ready);
    predict_pixel(value);
    pixels_sent++;
  endtask

  // Drops valid, waits for every queued result, then lets a trailing pixel
  // that causes no result work its way through the core.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_config(idx, value);
  endtask

  task automatic program_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    quiesce();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // Reset sizes are 1024 x 1024, so a handful of pixels stay in row 0 and
  // must produce nothing.
  task automatic test_reset_sizes();
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
  endtask

  // Smallest frame, reached through clamped zero sizes. Two 3x3 frames with
  // a strong vertical edge and a strong horizontal edge; each has one
  // interior pixel and ends with the three-result pixel carrying frame_last.
  localparam logic [18*PIX_W-1:0] EDGE_PIXELS = {
    8'd255, 8'd7,   8'd0,
    8'd255, 8'd128, 8'd0,
    8'd255, 8'd200, 8'd0,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd255,
    8'd255, 8'd255, 8'd255
  };

  task automatic test_edge_frames();
    program_frame(16'd0, 16'd0);
    for (int i = 0; i < 18; i++) send_pixel(EDGE_PIXELS[(17 - i) * PIX_W +: PIX_W]);
  endtask

  // A write to either register restarts the frame in the middle of a row.
  task automatic test_frame_restart();
    program_frame(16'd5, 16'd4);
    for (int i = 0; i < 8; i++) send_pixel(random_pixel());
    quiesce();
    write_reg(REG_IMAGE_WIDTH, 16'd5);
    for (int i = 0; i < 21; i++) send_pixel(random_pixel());
    quiesce();
    write_reg(REG_IMAGE_HEIGHT, 16'd4);
    for (int i = 0; i < 12; i++) send_pixel(random_pixel());
  endtask

  // The receiver holds off for a long stretch while pixels keep coming
  // back to back, so the core fills up and has to stall its input.
  task automatic test_output_backpressure();
    program_frame(16'd4, 16'd5);
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_requests++;
    for (int i = 0; i < 16; i++) send_pixel(random_pixel());
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Oversized values clamp to the full line length and the largest height,
  // so the first pixels of such a frame stay in row 0 and give nothing.
  task automatic test_wide_frame();
    program_frame(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel());
  endtask

  // Random small frames, a few with sizes below the minimum, with random
  // idling on each side; some phases run with no idling at all.
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned count;
    while (random_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      program_frame(CFG_W'(w), CFG_W'(h));
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      count = active_width() * active_height() + $urandom_range(0, active_width() + 2);
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      for (int unsigned i = 0; i < count; i++) send_pixel(random_pixel());
      random_items += count;
    end
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: drives out_ready, with random stalls and the requested long
  // hold, which it counts itself.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
        out_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        stall = random_gap() + 1;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    sobel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction at row %0d col %0d", out_row, out_col);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("grad_x", want.gx, grad_x);
        check_field("grad_y", want.gy, grad_y);
        check_field("magnitude", want.mag, magnitude);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("run_last", want.run_last, run_last);
        check_field("frame_last", want.frame_last, frame_last);
        results_checked++;
        if (frame_last === 1'b1) frames_seen++;
      end
    end
  end

  // Watchdog: too long without a transaction on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held at the start and never asserted again.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    for (int i = 0; i < LINE_DEPTH; i++) begin
      rows_two_back[i] = '0;
      rows_one_back[i] = '0;
    end
    foreach (window_pix[i]) window_pix[i] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_sizes();
    test_edge_frames();
    test_frame_restart();
    test_output_backpressure();
    test_wide_frame();
    test_random_frames();
    quiesce();

    $display("Covered reset, clamped and full sizes, mid-frame restarts and a long output hold.");
    $display("%0d pixels in, %0d results checked, %0d frame ends, %0d mismatches.",
             pixels_sent, results_checked, frames_seen, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sgm_pkg.sv
rtl/core/sgm_line_ram.sv
rtl/core/sgm_isqrt.sv
rtl/core/sobel_gradient_magnitude_top.sv
tb/testbench.sv
